>>> rtl/cmap_pkg.sv
// ----------------------------------------------------------------------------
// cmap_pkg
// Shared types, codes and the sine table function of the cone map block.
// ----------------------------------------------------------------------------
package cmap_pkg;

	localparam int CONE_DEPTH_DEF   = 64;
	localparam int CENTER_DEPTH_DEF = 64;
	localparam int TRIG_ENTRIES_DEF = 1024;
	localparam int MAX_OUT          = 64;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [1:0] OP_POSE = 2'd0;
	localparam logic [1:0] OP_DET  = 2'd1;
	localparam logic [1:0] OP_FEND = 2'd2;

	localparam logic [2:0] KIND_NEW    = 3'd0;
	localparam logic [2:0] KIND_MERGED = 3'd1;
	localparam logic [2:0] KIND_IGN    = 3'd2;
	localparam logic [2:0] KIND_FULL   = 3'd3;
	localparam logic [2:0] KIND_CENTER = 3'd4;

	localparam int F_RED_CHK   = 0;
	localparam int F_BLUE_CHK  = 1;
	localparam int F_CEN_CHK   = 2;
	localparam int F_BLUE_SEEN = 3;
	localparam int F_RED_SEEN  = 4;
	localparam int F_CEN_SEEN  = 5;
	localparam int F_RED_PEND  = 6;
	localparam int F_BLUE_PEND = 7;

	typedef struct packed {
		logic signed [23:0] y;
		logic signed [23:0] x;
	} point_t;

	typedef struct packed {
		logic signed [17:0] s;
		logic signed [17:0] c;
	} trig_t;

	// Quarter wave sine in Q16 from an angle in Q30 of a quarter turn.
	function automatic logic [63:0] cmap_qsine(input logic [63:0] f);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x  = (f * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t  = Q30_ONE - x2 / 110;
		t  = Q30_ONE - ((x2 * t) >> 30) / 72;
		t  = Q30_ONE - ((x2 * t) >> 30) / 42;
		t  = Q30_ONE - ((x2 * t) >> 30) / 20;
		t  = Q30_ONE - ((x2 * t) >> 30) / 6;
		return (((x * t) >> 30) + 64'd8192) >> 14;
	endfunction

	function automatic trig_t cmap_trig(input logic [31:0] a);
		logic [63:0] f;
		logic [63:0] p;
		logic [63:0] r;
		trig_t       t;
		f = {34'd0, a[29:0]};
		p = cmap_qsine(f);
		r = cmap_qsine(Q30_ONE - f);
		unique case (a[31:30])
			2'd0: begin t.s = 18'(p);  t.c = 18'(r);  end
			2'd1: begin t.s = 18'(r);  t.c = 18'(-p); end
			2'd2: begin t.s = 18'(-p); t.c = 18'(-r); end
			2'd3: begin t.s = 18'(-r); t.c = 18'(p);  end
		endcase
		return t;
	endfunction

endpackage

>>> rtl/cmap_cell.sv
// ----------------------------------------------------------------------------
// cmap_cell
// One stored point of a circulating point list.
// ----------------------------------------------------------------------------
module cmap_cell import cmap_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  point_t d,
	output point_t q
);

	point_t cell_q;

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= d;
		end
	end

	assign q = cell_q;

endmodule

>>> rtl/cmap_ring.sv
// ----------------------------------------------------------------------------
// cmap_ring
// Ring of point cells that rotates one place per step, with a squared
// distance test of the head cell against a query point.
// ----------------------------------------------------------------------------
module cmap_ring import cmap_pkg::*; #(
	parameter int DEPTH = CONE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        prime,
	input  logic        step,
	input  point_t      tail_d,
	input  point_t      qpt,
	input  logic [31:0] gate,
	output point_t      head,
	output logic        near
);

	point_t cq [DEPTH];
	point_t cd [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		if (k == DEPTH - 1) begin : g_tail
			assign cd[k] = tail_d;
		end else begin : g_mid
			assign cd[k] = cq[k + 1];
		end
		cmap_cell u_cell (
			.clk (clk),
			.en  (step),
			.d   (cd[k]),
			.q   (cq[k])
		);
	end

	point_t             src;
	logic signed [24:0] dx;
	logic signed [24:0] dy;
	logic signed [49:0] dxp;
	logic signed [49:0] dyp;
	logic        [49:0] dxx_q;
	logic        [49:0] dyy_q;

	// The squares are taken one cell ahead so that they match the head after the step.
	assign src = step ? cq[1] : cq[0];
	assign dx  = 25'(src.x) - 25'(qpt.x);
	assign dy  = 25'(src.y) - 25'(qpt.y);
	assign dxp = dx * dx;
	assign dyp = dy * dy;

	always_ff @(posedge clk) begin
		if (prime || step) begin
			dxx_q <= dxp;
			dyy_q <= dyp;
		end
	end

	assign head = cq[0];
	assign near = ({1'b0, dxx_q} + {1'b0, dyy_q}) < {19'd0, gate};

endmodule

>>> rtl/cmap_rotate.sv
// ----------------------------------------------------------------------------
// cmap_rotate
// Camera distances to body metres and rotation into the world frame.
// ----------------------------------------------------------------------------
module cmap_rotate import cmap_pkg::*; #(
	parameter int TRIG_ENTRIES = TRIG_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] fwd,
	input  logic signed [15:0] lat,
	input  logic        [11:0] offset,
	input  logic        [15:0] heading,
	input  logic signed [23:0] vx,
	input  logic signed [23:0] vy,
	output logic               done,
	output point_t             pt
);

	localparam int          PW    = (TRIG_ENTRIES > 1) ? $clog2(TRIG_ENTRIES) : 1;
	localparam logic [25:0] BIAS  = 26'd13107250;
	localparam logic [25:0] RECIP = 26'd42949672;

	trig_t rom_w [TRIG_ENTRIES];

	for (genvar g = 0; g < TRIG_ENTRIES; g++) begin : g_rom
		localparam logic [31:0] ANG = 32'((64'(g) << 32) / TRIG_ENTRIES);
		assign rom_w[g] = cmap_trig(ANG);
	end

	logic [25:0] nf_w;
	logic [25:0] nl_w;
	logic [50:0] pf_w;
	logic [50:0] pl_w;
	logic [32:0] hp_w;

	// Biased numerators keep the divide by 100 on positive values.
	assign nf_w = {{2{fwd[15]}}, fwd, 8'd0} + BIAS;
	assign nl_w = {{2{lat[15]}}, lat, 8'd0} + BIAS;
	assign pf_w = 51'(nf_w[24:0]) * 51'(RECIP);
	assign pl_w = 51'(nl_w[24:0]) * 51'(RECIP);
	assign hp_w = {17'd0, heading} * 33'(TRIG_ENTRIES);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [24:0] nf_s1, nl_s1;
	logic [18:0] qf_s1, ql_s1;
	logic [PW-1:0] ph_s1;

	logic [25:0] rf_w, rl_w;
	logic [18:0] qf_w, ql_w;

	assign rf_w = 26'(nf_s1) - 26'(qf_s1) * 26'd100;
	assign rl_w = 26'(nl_s1) - 26'(ql_s1) * 26'd100;
	assign qf_w = qf_s1 + 19'(rf_w >= 26'd100);
	assign ql_w = ql_s1 + 19'(rl_w >= 26'd100);

	logic signed [19:0] xb_s2, yb_s2;
	trig_t              sc_s2;
	logic signed [37:0] xc_s3, ys_s3, yc_s3, xs_s3;

	logic signed [39:0] sx_w, sy_w;
	logic signed [25:0] gx_w, gy_w;
	point_t             pt_q;

	assign sx_w = 40'(xc_s3) - 40'(ys_s3) + 40'sd32768;
	assign sy_w = 40'(yc_s3) + 40'(xs_s3) + 40'sd32768;
	assign gx_w = 26'(sx_w >>> 16) + 26'(vx);
	assign gy_w = 26'(sy_w >>> 16) + 26'(vy);

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		if (v > 26'sd8388607) begin
			return 24'sd8388607;
		end else if (v < -26'sd8388608) begin
			return -24'sd8388608;
		end
		return 24'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		nf_s1 <= nf_w[24:0];
		nl_s1 <= nl_w[24:0];
		qf_s1 <= pf_w[50:32];
		ql_s1 <= pl_w[50:32];
		ph_s1 <= hp_w[16 +: PW];
		xb_s2 <= 20'(qf_w) - 20'sd131072 - 20'(offset);
		yb_s2 <= 20'sd131072 - 20'(ql_w);
		sc_s2 <= rom_w[ph_s1];
		xc_s3 <= xb_s2 * sc_s2.c;
		ys_s3 <= yb_s2 * sc_s2.s;
		yc_s3 <= yb_s2 * sc_s2.c;
		xs_s3 <= xb_s2 * sc_s2.s;
		if (v_s3) begin
			pt_q.x <= sat24(gx_w);
			pt_q.y <= sat24(gy_w);
		end
	end

	assign done = v_s4;
	assign pt   = pt_q;

endmodule

>>> rtl/cone_map_association_core.sv
// ----------------------------------------------------------------------------
// cone_map_association_core
// Red and blue cone maps with centre points, built from pose and detections.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: tuser carries the operation (pose, detection,
// frame end) and tdata the pose and detection fields. Results leave on the m_
// channel with the kind in tuser, the point in tdata and tlast on the final one.
// Registers are written on the cfg_ channel, which is always ready.
// A pose request is taken in the idle state and leaves the core idle. A detection
// result passes the rotation pipeline, a prime of the distance unit, a scan while
// the ring of its colour turns once past it, and the load of the result, which
// waits for a free output slot. The next request is taken back in the idle state.
// An ignored detection goes straight to the load of its result.
// A frame end with at least two cones of each colour and a positive pose x turns
// both cone rings once, the centre ring once or twice for the duplicate test and
// store, and once more to list the centres; otherwise it only lists the centres.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken.
// After reset the lists are empty, the pose is zero and the registers hold
// their default values. When the receiver stalls, the listing pass holds.
// ----------------------------------------------------------------------------
module cone_map_association_core import cmap_pkg::*; #(
	parameter int CONE_DEPTH   = CONE_DEPTH_DEF,
	parameter int CENTER_DEPTH = CENTER_DEPTH_DEF,
	parameter int TRIG_ENTRIES = TRIG_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pose_x, pose_y, heading, cone_color, dist_forward_cm, dist_lateral_cm,
	// box_bottom_row, zero fill
	input  logic [111:0] s_tdata,
	// op
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// point_x, point_y
	output logic [47:0]  m_tdata,
	// kind
	output logic [2:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int MAXD = (CONE_DEPTH > CENTER_DEPTH) ? CONE_DEPTH : CENTER_DEPTH;
	localparam int SW   = $clog2(MAXD + 1);
	localparam int CCW  = $clog2(CONE_DEPTH + 1);
	localparam int NCW  = $clog2(CENTER_DEPTH + 1);

	localparam logic [2:0] REG_RED_GATE  = 3'd0;
	localparam logic [2:0] REG_BLUE_GATE = 3'd1;
	localparam logic [2:0] REG_CEN_GATE  = 3'd2;
	localparam logic [2:0] REG_CAM_OFF   = 3'd3;
	localparam logic [2:0] REG_MIN_ROW   = 3'd4;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ROT    = 4'd1;
	localparam logic [3:0] ST_PRIME  = 4'd2;
	localparam logic [3:0] ST_SCAN   = 4'd3;
	localparam logic [3:0] ST_DRES   = 4'd4;
	localparam logic [3:0] ST_FECONE = 4'd5;
	localparam logic [3:0] ST_FECALC = 4'd6;
	localparam logic [3:0] ST_CPRIME = 4'd7;
	localparam logic [3:0] ST_CSCAN  = 4'd8;
	localparam logic [3:0] ST_CWRITE = 4'd9;
	localparam logic [3:0] ST_EMIT   = 4'd10;

	logic signed [23:0] in_px, in_py;
	logic        [15:0] in_hd;
	logic        [1:0]  in_color;
	logic signed [15:0] in_fwd, in_lat;
	logic        [11:0] in_row;

	assign in_px    = s_tdata[23:0];
	assign in_py    = s_tdata[47:24];
	assign in_hd    = s_tdata[63:48];
	assign in_color = s_tdata[65:64];
	assign in_fwd   = s_tdata[81:66];
	assign in_lat   = s_tdata[97:82];
	assign in_row   = s_tdata[109:98];

	logic [31:0] red_gate_q, blue_gate_q, cen_gate_q;
	logic [11:0] cam_off_q, min_row_q;

	logic [3:0]         state_q;
	logic [SW-1:0]      idx_q;
	logic signed [23:0] vx_q, vy_q;
	logic [15:0]        hd_q;
	logic [CCW-1:0]     rcnt_q, bcnt_q;
	logic [NCW-1:0]     ccnt_q;
	logic [7:0]         flags_q;
	logic               col_q, found_q, near_any_q, wa_en_q, wb_en_q;
	logic [2:0]         kind_q;
	point_t             g_q, r1_q, r2_q, b1_q, b2_q, cen_q, wa_q, wb_q;

	logic   ov_q, olast_q;
	logic [2:0] okind_q;
	point_t opt_q;

	logic   rot_done;
	point_t rot_pt;

	point_t rhead, bhead, chead;
	logic   rnear, bnear, cnear;
	logic   rp, rs, bp, bs, cp, cs;
	point_t rtail, btail, ctail, dtail, hsel, avg;

	logic           accept, ignore_det, fe_cond, slot_free, last_cone, last_cen;
	logic [CCW-1:0] cnt_sel;
	logic           chk_sel, near_sel, merge_now, app_now;
	logic           emit_here, emit_last, cnear_now, out_load;
	logic [NCW-1:0] ccnt_next;
	logic signed [24:0] sx, sy;
	logic signed [25:0] cx_sum, cy_sum;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !ov_q || m_tready;
	assign last_cone = (idx_q == SW'(CONE_DEPTH - 1));
	assign last_cen  = (idx_q == SW'(CENTER_DEPTH - 1));

	assign ignore_det = in_color[1] || (in_row < min_row_q) || vx_q[23] || (vx_q == 24'sd0);
	assign fe_cond    = (rcnt_q >= CCW'(2)) && (bcnt_q >= CCW'(2)) && !vx_q[23] &&
		(vx_q != 24'sd0);

	assign hsel      = col_q ? bhead : rhead;
	assign cnt_sel   = col_q ? bcnt_q : rcnt_q;
	assign chk_sel   = col_q ? flags_q[F_BLUE_CHK] : flags_q[F_RED_CHK];
	assign near_sel  = col_q ? bnear : rnear;
	assign merge_now = chk_sel && !found_q && (idx_q < SW'(cnt_sel)) && near_sel;
	assign app_now   = !found_q && (idx_q == SW'(cnt_sel));

	assign sx    = 25'(hsel.x) + 25'(g_q.x);
	assign sy    = 25'(hsel.y) + 25'(g_q.y);
	assign avg.x = sx[24:1];
	assign avg.y = sy[24:1];
	assign dtail = merge_now ? avg : (app_now ? g_q : hsel);

	assign cx_sum = 26'(r1_q.x) + 26'(r2_q.x) + 26'(b1_q.x) + 26'(b2_q.x);
	assign cy_sum = 26'(r1_q.y) + 26'(r2_q.y) + 26'(b1_q.y) + 26'(b2_q.y);

	assign emit_here = (int'(idx_q) < int'(ccnt_q)) && (int'(idx_q) < MAX_OUT);
	assign emit_last = (int'(idx_q) + 1 == int'(ccnt_q)) || (int'(idx_q) + 1 == MAX_OUT);
	assign cnear_now = cnear && (idx_q < SW'(ccnt_q));
	assign ccnt_next = ccnt_q + NCW'(wa_en_q && (int'(ccnt_q) < CENTER_DEPTH)) +
		NCW'(wb_en_q && (int'(ccnt_q) + 1 < CENTER_DEPTH));

	assign rp = (state_q == ST_PRIME) && !col_q;
	assign bp = (state_q == ST_PRIME) && col_q;
	assign cp = (state_q == ST_CPRIME);
	assign rs = ((state_q == ST_SCAN) && !col_q) || (state_q == ST_FECONE);
	assign bs = ((state_q == ST_SCAN) && col_q) || (state_q == ST_FECONE);
	assign cs = (state_q == ST_CSCAN) || (state_q == ST_CWRITE) ||
		((state_q == ST_EMIT) && (!emit_here || slot_free));

	assign rtail = ((state_q == ST_SCAN) && !col_q) ? dtail : rhead;
	assign btail = ((state_q == ST_SCAN) && col_q) ? dtail : bhead;

	always_comb begin
		ctail = chead;
		if (state_q == ST_CWRITE) begin
			if (wa_en_q && (int'(idx_q) == int'(ccnt_q))) begin
				ctail = wa_q;
			end else if (wb_en_q && (int'(idx_q) == int'(ccnt_q) + 1)) begin
				ctail = wb_q;
			end
		end
	end

	assign out_load = ((state_q == ST_DRES) && slot_free) ||
		((state_q == ST_EMIT) && emit_here && slot_free);

	cmap_rotate #(.TRIG_ENTRIES(TRIG_ENTRIES)) u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && (s_tuser == OP_DET) && !ignore_det),
		.fwd     (in_fwd),
		.lat     (in_lat),
		.offset  (cam_off_q),
		.heading (hd_q),
		.vx      (vx_q),
		.vy      (vy_q),
		.done    (rot_done),
		.pt      (rot_pt)
	);

	cmap_ring #(.DEPTH(CONE_DEPTH)) u_red (
		.clk (clk), .prime (rp), .step (rs), .tail_d (rtail), .qpt (g_q),
		.gate (red_gate_q), .head (rhead), .near (rnear)
	);

	cmap_ring #(.DEPTH(CONE_DEPTH)) u_blue (
		.clk (clk), .prime (bp), .step (bs), .tail_d (btail), .qpt (g_q),
		.gate (blue_gate_q), .head (bhead), .near (bnear)
	);

	cmap_ring #(.DEPTH(CENTER_DEPTH)) u_center (
		.clk (clk), .prime (cp), .step (cs), .tail_d (ctail), .qpt (cen_q),
		.gate (cen_gate_q), .head (chead), .near (cnear)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_gate_q  <= 32'd65536;
			blue_gate_q <= 32'd131072;
			cen_gate_q  <= 32'd131072;
			cam_off_q   <= 12'd56;
			min_row_q   <= 12'd330;
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			vx_q        <= '0;
			vy_q        <= '0;
			hd_q        <= '0;
			rcnt_q      <= '0;
			bcnt_q      <= '0;
			ccnt_q      <= '0;
			flags_q     <= '0;
			col_q       <= 1'b0;
			found_q     <= 1'b0;
			near_any_q  <= 1'b0;
			wa_en_q     <= 1'b0;
			wb_en_q     <= 1'b0;
			kind_q      <= KIND_NEW;
			ov_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_RED_GATE:  red_gate_q  <= cfg_data;
					REG_BLUE_GATE: blue_gate_q <= cfg_data;
					REG_CEN_GATE:  cen_gate_q  <= cfg_data;
					REG_CAM_OFF:   cam_off_q   <= cfg_data[11:0];
					REG_MIN_ROW:   min_row_q   <= cfg_data[11:0];
					default: ;
				endcase
			end

			if (out_load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q      <= '0;
						found_q    <= 1'b0;
						near_any_q <= 1'b0;
						unique case (s_tuser)
							OP_POSE: begin
								vx_q <= in_px;
								vy_q <= in_py;
								hd_q <= in_hd;
							end
							OP_DET: begin
								if (ignore_det) begin
									kind_q  <= KIND_IGN;
									state_q <= ST_DRES;
								end else begin
									col_q   <= in_color[0];
									state_q <= ST_ROT;
								end
							end
							OP_FEND: state_q <= fe_cond ? ST_FECONE : ST_EMIT;
							default: ;
						endcase
					end
				end
				ST_ROT: begin
					if (rot_done) begin
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: state_q <= ST_SCAN;
				ST_SCAN: begin
					idx_q <= idx_q + SW'(1);
					if (merge_now) begin
						found_q <= 1'b1;
					end
					if (last_cone) begin
						idx_q   <= '0;
						state_q <= ST_DRES;
						if (found_q || merge_now) begin
							kind_q <= KIND_MERGED;
						end else if (int'(cnt_sel) < CONE_DEPTH) begin
							kind_q <= KIND_NEW;
							if (col_q) begin
								bcnt_q <= bcnt_q + CCW'(1);
								if (chk_sel) flags_q[F_BLUE_PEND] <= 1'b1;
								else flags_q[F_BLUE_SEEN] <= 1'b1;
							end else begin
								rcnt_q <= rcnt_q + CCW'(1);
								if (chk_sel) flags_q[F_RED_PEND] <= 1'b1;
								else flags_q[F_RED_SEEN] <= 1'b1;
							end
						end else begin
							kind_q <= KIND_FULL;
						end
					end
				end
				ST_DRES: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FECONE: begin
					idx_q <= idx_q + SW'(1);
					if (last_cone) begin
						idx_q   <= '0;
						state_q <= ST_FECALC;
					end
				end
				ST_FECALC: begin
					near_any_q <= 1'b0;
					if (!flags_q[F_CEN_CHK]) begin
						wa_en_q              <= 1'b1;
						wb_en_q              <= 1'b1;
						flags_q[F_CEN_SEEN]  <= 1'b1;
						state_q              <= ST_CWRITE;
					end else begin
						state_q <= ST_CPRIME;
					end
				end
				ST_CPRIME: state_q <= ST_CSCAN;
				ST_CSCAN: begin
					idx_q      <= idx_q + SW'(1);
					near_any_q <= near_any_q || cnear_now;
					if (last_cen) begin
						idx_q <= '0;
						if (!(near_any_q || cnear_now) && flags_q[F_RED_PEND] &&
							flags_q[F_BLUE_PEND]) begin
							wa_en_q              <= 1'b1;
							wb_en_q              <= 1'b0;
							flags_q[F_RED_PEND]  <= 1'b0;
							flags_q[F_BLUE_PEND] <= 1'b0;
							state_q              <= ST_CWRITE;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_CWRITE: begin
					idx_q <= idx_q + SW'(1);
					if (last_cen) begin
						idx_q   <= '0;
						ccnt_q  <= ccnt_next;
						wa_en_q <= 1'b0;
						wb_en_q <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cs) begin
						idx_q <= idx_q + SW'(1);
						if (last_cen) begin
							idx_q <= '0;
							if (flags_q[F_RED_SEEN])  flags_q[F_RED_CHK]  <= 1'b1;
							if (flags_q[F_BLUE_SEEN]) flags_q[F_BLUE_CHK] <= 1'b1;
							if (flags_q[F_CEN_SEEN])  flags_q[F_CEN_CHK]  <= 1'b1;
							flags_q[F_RED_SEEN]  <= 1'b0;
							flags_q[F_BLUE_SEEN] <= 1'b0;
							flags_q[F_CEN_SEEN]  <= 1'b0;
							state_q              <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (s_tuser == OP_DET) && ignore_det) begin
			g_q <= '0;
		end else if ((state_q == ST_ROT) && rot_done) begin
			g_q <= rot_pt;
		end
		if (state_q == ST_FECONE) begin
			if (int'(idx_q) == int'(rcnt_q) - 1) r1_q <= rhead;
			if (int'(idx_q) == int'(rcnt_q) - 2) r2_q <= rhead;
			if (int'(idx_q) == int'(bcnt_q) - 1) b1_q <= bhead;
			if (int'(idx_q) == int'(bcnt_q) - 2) b2_q <= bhead;
		end
		if (state_q == ST_FECALC) begin
			cen_q.x <= cx_sum[25:2];
			cen_q.y <= cy_sum[25:2];
			wa_q.x  <= vx_q;
			wa_q.y  <= vy_q;
			wb_q.x  <= cx_sum[25:2];
			wb_q.y  <= cy_sum[25:2];
		end
		if ((state_q == ST_CSCAN) && last_cen) begin
			wa_q <= cen_q;
		end
		if (out_load) begin
			if (state_q == ST_DRES) begin
				okind_q <= kind_q;
				opt_q   <= g_q;
				olast_q <= 1'b1;
			end else begin
				okind_q <= KIND_CENTER;
				opt_q   <= chead;
				olast_q <= emit_last;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {opt_q.y, opt_q.x};
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;

endmodule
